// ----- rtl/core/frim_pkg.sv -----
// Shared constants, state encoding and controller/datapath interface types
// for the fragment reassembly unit. No dependencies.
`default_nettype none

package frim_pkg;

  localparam int FRAME_BYTES   = 8;
  localparam int MAX_INTERVALS = 8;
  localparam int STORE_BYTES   = 256;
  localparam int WORD_BYTES    = 8;

  localparam int ADDR_W = $clog2(STORE_BYTES);
  localparam int VAL_W  = $clog2(STORE_BYTES + 1);
  localparam int CNT_W  = $clog2(MAX_INTERVALS + 1);
  localparam int IDX_W  = $clog2(MAX_INTERVALS);
  localparam int EXP_W  = 8;
  localparam int WCNT_W = $clog2(STORE_BYTES / WORD_BYTES + 1);

  // Header byte layout and the first frame's extra total-length byte.
  localparam int        SEQ_SHIFT   = 3;
  localparam logic [7:0] LCODE_MASK = 8'h07;
  localparam int        SEQ0_SRC    = 2;
  localparam int        SEQN_SRC    = 1;
  localparam int        MIN_FLEN    = 2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EVAL,
    ST_CHECK,
    ST_INSERT,
    ST_MPREV,
    ST_MNEXT,
    ST_WRITE,
    ST_FINAL,
    ST_RESULT,
    ST_READ,
    ST_EMIT,
    ST_EMPTY
  } frim_state_e;

  typedef struct packed {
    logic capture;
    logic eval;
    logic check;
    logic insert;
    logic merge_prev;
    logic merge_next;
    logic write_byte;
    logic final_chk;
    logic rd_step;
    logic load_plain;
    logic load_word;
    logic load_empty;
  } frim_cmd_t;

  typedef struct packed {
    logic eval_ok;
    logic do_insert;
    logic write_last;
    logic pkt_done;
    logic pkt_empty;
    logic rd_done;
    logic words_more;
    logic out_free;
  } frim_sts_t;

endpackage

`default_nettype wire

// ----- rtl/core/fragment_reassembly_interval_merge_unit.sv -----
// Top level of the fragment reassembly unit: controller plus datapath.
// Depends on frim_pkg, frim_ctrl and frim_dp.
//
//  channel | direction | handshake               | payload
//  in      | input     | in_valid_i / in_stall_o  | frame_bytes, frame_length, command
//  out     | output    | out_valid_o / out_stall_i| ack, complete, packet_command,
//          |           |                          | packet_word, word_bytes, packet_total, last
//
// One request at a time. A stored frame writes its payload bytes through one store
// write port, one byte a cycle, and a completed packet is read back word by word
// through one store read port.
// Reset is asynchronous, active low; the byte store needs no clearing pass.
// A stalled output holds the request side until its result register drains.
`default_nettype none

module fragment_reassembly_interval_merge_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [63:0] frame_bytes_i,
  input  wire logic [7:0]  frame_length_i,
  input  wire logic [7:0]  command_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             ack_o,
  output logic             complete_o,
  output logic [7:0]       packet_command_o,
  output logic [63:0]      packet_word_o,
  output logic [3:0]       word_bytes_o,
  output logic [7:0]       packet_total_o,
  output logic             last_o
);

  frim_pkg::frim_cmd_t cmd;
  frim_pkg::frim_sts_t sts;

  frim_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .busy_o     (in_stall_o)
  );

  frim_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .frame_bytes_i    (frame_bytes_i),
    .frame_length_i   (frame_length_i),
    .command_i        (command_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .ack_o            (ack_o),
    .complete_o       (complete_o),
    .packet_command_o (packet_command_o),
    .packet_word_o    (packet_word_o),
    .word_bytes_o     (word_bytes_o),
    .packet_total_o   (packet_total_o),
    .last_o           (last_o)
  );

endmodule

`default_nettype wire

// ----- rtl/core/frim_ctrl.sv -----
// Sequencing state machine of the fragment reassembly unit.
// Depends on frim_pkg for the state type and the command/status structs.
`default_nettype none

module frim_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire frim_pkg::frim_sts_t sts_i,
  output frim_pkg::frim_cmd_t    cmd_o,
  output logic                   busy_o
);

  frim_pkg::frim_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= frim_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      frim_pkg::ST_IDLE:   if (in_valid_i) state_d = frim_pkg::ST_EVAL;
      frim_pkg::ST_EVAL:   state_d = sts_i.eval_ok ? frim_pkg::ST_CHECK : frim_pkg::ST_RESULT;
      frim_pkg::ST_CHECK:  state_d = sts_i.do_insert ? frim_pkg::ST_INSERT : frim_pkg::ST_RESULT;
      frim_pkg::ST_INSERT: state_d = frim_pkg::ST_MPREV;
      frim_pkg::ST_MPREV:  state_d = frim_pkg::ST_MNEXT;
      frim_pkg::ST_MNEXT:  state_d = frim_pkg::ST_WRITE;
      frim_pkg::ST_WRITE:  if (sts_i.write_last) state_d = frim_pkg::ST_FINAL;
      frim_pkg::ST_FINAL: begin
        if (!sts_i.pkt_done) begin
          state_d = frim_pkg::ST_RESULT;
        end else if (sts_i.pkt_empty) begin
          state_d = frim_pkg::ST_EMPTY;
        end else begin
          state_d = frim_pkg::ST_READ;
        end
      end
      frim_pkg::ST_RESULT: if (sts_i.out_free) state_d = frim_pkg::ST_IDLE;
      frim_pkg::ST_EMPTY:  if (sts_i.out_free) state_d = frim_pkg::ST_IDLE;
      frim_pkg::ST_READ:   if (sts_i.rd_done) state_d = frim_pkg::ST_EMIT;
      frim_pkg::ST_EMIT: begin
        if (sts_i.out_free) begin
          state_d = sts_i.words_more ? frim_pkg::ST_READ : frim_pkg::ST_IDLE;
        end
      end
      default: state_d = frim_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    case (state_q)
      frim_pkg::ST_IDLE: begin
        busy_o        = 1'b0;
        cmd_o.capture = in_valid_i;
      end
      frim_pkg::ST_EVAL:   cmd_o.eval       = 1'b1;
      frim_pkg::ST_CHECK:  cmd_o.check      = 1'b1;
      frim_pkg::ST_INSERT: cmd_o.insert     = 1'b1;
      frim_pkg::ST_MPREV:  cmd_o.merge_prev = 1'b1;
      frim_pkg::ST_MNEXT:  cmd_o.merge_next = 1'b1;
      frim_pkg::ST_WRITE:  cmd_o.write_byte = 1'b1;
      frim_pkg::ST_FINAL:  cmd_o.final_chk  = 1'b1;
      frim_pkg::ST_RESULT: cmd_o.load_plain = sts_i.out_free;
      frim_pkg::ST_EMPTY:  cmd_o.load_empty = sts_i.out_free;
      frim_pkg::ST_READ:   cmd_o.rd_step    = 1'b1;
      frim_pkg::ST_EMIT:   cmd_o.load_word  = sts_i.out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/core/frim_dp.sv -----
// Datapath of the fragment reassembly unit: frame register, interval table,
// packet byte store and the output register. Depends on frim_pkg.
`default_nettype none

module frim_dp (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire frim_pkg::frim_cmd_t cmd_i,
  output frim_pkg::frim_sts_t      sts_o,
  input  wire logic [63:0]         frame_bytes_i,
  input  wire logic [7:0]          frame_length_i,
  input  wire logic [7:0]          command_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic                     ack_o,
  output logic                     complete_o,
  output logic [7:0]               packet_command_o,
  output logic [63:0]              packet_word_o,
  output logic [3:0]               word_bytes_o,
  output logic [7:0]               packet_total_o,
  output logic                     last_o
);

  localparam int MI = frim_pkg::MAX_INTERVALS;
  localparam int VW = frim_pkg::VAL_W;
  localparam int CW = frim_pkg::CNT_W;
  localparam int IW = frim_pkg::IDX_W;
  localparam int AW = frim_pkg::ADDR_W;
  localparam int EW = frim_pkg::EXP_W;
  localparam int WW = frim_pkg::WCNT_W;

  // Captured request.
  logic [63:0] frame_q;
  logic [7:0]  flen_q;
  logic [7:0]  cmd_q;

  // Control state.
  logic [EW-1:0] exp_q;
  logic          live_q;
  logic [CW-1:0] count_q;
  logic [CW-1:0] pos_q;
  logic          res_ack_q;
  logic [2:0]    wc_q;
  logic [3:0]    rb_q;
  logic [WW-1:0] wcnt_q;
  logic          out_valid_q;

  // Fill parameters.
  logic [VW-1:0] off_q;
  logic [2:0]    flen_fill_q;
  logic [2:0]    src_q;

  // Interval table and byte store.
  logic [VW-1:0] st_q [MI];
  logic [VW-1:0] ln_q [MI];
  logic [VW-1:0] st_d [MI];
  logic [VW-1:0] ln_d [MI];
  logic [7:0]    mem [frim_pkg::STORE_BYTES];
  logic [7:0]    rdata_q;
  logic [63:0]   word_q;

  // ---------------- request decode ----------------
  logic [7:0]  hdr;
  logic [4:0]  seq;
  logic [2:0]  lcode;
  logic [7:0]  tot;
  logic        len_ok, seq0;
  logic [9:0]  psum;
  logic        plen_ok;
  logic [EW-1:0] plen;
  logic [VW-1:0] off_n;

  assign hdr   = frame_q[7:0];
  assign seq   = hdr[7:frim_pkg::SEQ_SHIFT];
  assign lcode = 3'(hdr & frim_pkg::LCODE_MASK);
  assign tot   = frame_q[15:8];
  assign seq0  = (seq == 5'd0);
  assign len_ok = (flen_q >= 8'(frim_pkg::MIN_FLEN)) &&
                  (flen_q <= 8'(frim_pkg::FRAME_BYTES)) &&
                  ((8'(lcode) + 8'd1) == flen_q);
  assign psum = 10'(tot / frim_pkg::FRAME_BYTES) * 10'(frim_pkg::FRAME_BYTES - 1) +
                10'(tot % frim_pkg::FRAME_BYTES);
  assign plen_ok = (psum >= 10'(frim_pkg::MIN_FLEN)) &&
                   ((psum - 10'(frim_pkg::MIN_FLEN)) <= 10'(frim_pkg::STORE_BYTES)) &&
                   ((psum - 10'(frim_pkg::MIN_FLEN)) <= 10'd255);
  assign plen  = EW'(psum - 10'(frim_pkg::MIN_FLEN));
  assign off_n = VW'(VW'(seq) * VW'(frim_pkg::FRAME_BYTES - 1) - VW'(1));

  // ---------------- table search ----------------
  logic [VW:0]   fill_end;
  logic          range_bad, hit, hit_in, full, zero_len;
  logic [CW-1:0] le_cnt;
  logic [MI-1:0] adj;

  assign fill_end  = (VW+1)'(off_q) + (VW+1)'(flen_fill_q);
  assign range_bad = fill_end > (VW+1)'(frim_pkg::STORE_BYTES);
  assign full      = count_q >= CW'(MI);
  assign zero_len  = (flen_fill_q == 3'd0);

  always_comb begin
    logic [VW:0] e;
    hit    = 1'b0;
    hit_in = 1'b0;
    le_cnt = '0;
    for (int i = 0; i < MI; i++) begin
      e = (VW+1)'(st_q[i]) + (VW+1)'(ln_q[i]);
      if (CW'(i) < count_q) begin
        if ((off_q >= st_q[i]) && ((VW+1)'(off_q) < e)) begin
          hit = 1'b1;
          if (fill_end <= e) hit_in = 1'b1;
        end
        if (st_q[i] <= off_q) le_cnt = le_cnt + CW'(1);
      end
    end
  end

  // Pair i touches pair i+1 when the first interval ends where the next starts.
  always_comb begin
    adj = '0;
    for (int i = 0; i < MI - 1; i++) begin
      adj[i] = ((VW+1)'(st_q[i]) + (VW+1)'(ln_q[i])) == (VW+1)'(st_q[i+1]);
    end
  end

  logic [IW-1:0] pos_ix, pos_m1;
  logic          cond_prev, cond_next, do_merge;
  logic [IW-1:0] mk;

  assign pos_ix    = pos_q[IW-1:0];
  assign pos_m1    = IW'(pos_q - CW'(1));
  assign cond_prev = (pos_q != '0) && adj[pos_m1];
  assign cond_next = ((pos_q + CW'(1)) < count_q) && adj[pos_ix];
  assign do_merge  = (cmd_i.merge_prev && cond_prev) || (cmd_i.merge_next && cond_next);
  assign mk        = cmd_i.merge_prev ? pos_m1 : pos_ix;

  always_comb begin
    for (int j = 0; j < MI; j++) begin
      st_d[j] = st_q[j];
      ln_d[j] = ln_q[j];
      if (cmd_i.insert) begin
        if (IW'(j) == pos_ix) begin
          st_d[j] = off_q;
          ln_d[j] = VW'(flen_fill_q);
        end else if ((j > 0) && (IW'(j) > pos_ix)) begin
          st_d[j] = st_q[(j > 0) ? j - 1 : 0];
          ln_d[j] = ln_q[(j > 0) ? j - 1 : 0];
        end
      end else if (do_merge) begin
        if (IW'(j) == mk) begin
          ln_d[j] = ln_q[j] + ln_q[(j < MI - 1) ? j + 1 : j];
        end else if ((IW'(j) > mk) && (j < MI - 1)) begin
          st_d[j] = st_q[(j < MI - 1) ? j + 1 : j];
          ln_d[j] = ln_q[(j < MI - 1) ? j + 1 : j];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < MI; j++) begin
      st_q[j] <= st_d[j];
      ln_q[j] <= ln_d[j];
    end
  end

  // ---------------- byte store ----------------
  logic [2:0]  wsel;
  logic [AW-1:0] waddr;
  logic [WW+2:0] raddr_full;
  logic [AW-1:0] raddr;

  assign wsel       = src_q + wc_q;
  assign waddr      = AW'(off_q + VW'(wc_q));
  assign raddr_full = {wcnt_q, rb_q[2:0]};
  assign raddr      = raddr_full[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.write_byte) begin
      mem[waddr] <= frame_q[8*wsel +: 8];
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr];
  end

  // ---------------- word assembly ----------------
  logic [WW+2:0] rem;
  logic [3:0]    nb;
  logic [WW:0]   wnext;
  logic [2:0]    bidx;

  assign rem   = (WW+3)'(exp_q) - (WW+3)'({wcnt_q, 3'b000});
  assign nb    = (rem >= (WW+3)'(frim_pkg::WORD_BYTES)) ? 4'(frim_pkg::WORD_BYTES) : rem[3:0];
  assign wnext = (WW+1)'(wcnt_q) + (WW+1)'(1);
  assign bidx  = 3'(rb_q - 4'd1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_step && (rb_q != 4'd0)) begin
      word_q[8*bidx +: 8] <= ({1'b0, bidx} < nb) ? rdata_q : 8'h00;
    end
  end

  // ---------------- payload registers ----------------
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      frame_q <= frame_bytes_i;
      flen_q  <= frame_length_i;
      cmd_q   <= command_i;
    end
    if (cmd_i.eval) begin
      off_q       <= seq0 ? '0 : off_n;
      flen_fill_q <= seq0 ? 3'(lcode - 3'd1) : lcode;
      src_q       <= seq0 ? 3'(frim_pkg::SEQ0_SRC) : 3'(frim_pkg::SEQN_SRC);
    end
    if (cmd_i.load_plain) begin
      ack_o            <= res_ack_q;
      complete_o       <= 1'b0;
      packet_command_o <= '0;
      packet_word_o    <= '0;
      word_bytes_o     <= '0;
      packet_total_o   <= '0;
      last_o           <= 1'b1;
    end else if (cmd_i.load_empty) begin
      ack_o            <= 1'b1;
      complete_o       <= 1'b1;
      packet_command_o <= cmd_q;
      packet_word_o    <= '0;
      word_bytes_o     <= '0;
      packet_total_o   <= '0;
      last_o           <= 1'b1;
    end else if (cmd_i.load_word) begin
      ack_o            <= 1'b1;
      complete_o       <= 1'b1;
      packet_command_o <= cmd_q;
      packet_word_o    <= word_q;
      word_bytes_o     <= nb;
      packet_total_o   <= 8'(exp_q);
      last_o           <= !sts_o.words_more;
    end
  end

  // ---------------- control registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q       <= '0;
      live_q      <= 1'b0;
      count_q     <= '0;
      pos_q       <= '0;
      res_ack_q   <= 1'b0;
      wc_q        <= '0;
      rb_q        <= '0;
      wcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.capture) res_ack_q <= 1'b0;
      // A valid first frame restarts the packet even if it is rejected later.
      if (cmd_i.eval && len_ok && seq0 && plen_ok) begin
        exp_q   <= plen;
        live_q  <= 1'b1;
        count_q <= '0;
      end
      if (cmd_i.check) begin
        res_ack_q <= !range_bad && (hit ? hit_in : (zero_len && (count_q == CW'(1))));
        pos_q     <= le_cnt;
        wc_q      <= '0;
      end
      if (cmd_i.insert) count_q <= count_q + CW'(1);
      if (do_merge) begin
        count_q <= count_q - CW'(1);
        if (cmd_i.merge_prev) pos_q <= pos_q - CW'(1);
      end
      if (cmd_i.write_byte) wc_q <= wc_q + 3'd1;
      if (cmd_i.final_chk) begin
        res_ack_q <= (count_q == CW'(1));
        if (sts_o.pkt_done) live_q <= 1'b0;
        rb_q   <= '0;
        wcnt_q <= '0;
      end
      if (cmd_i.rd_step) rb_q <= rb_q + 4'd1;
      if (cmd_i.load_word) begin
        rb_q   <= '0;
        wcnt_q <= wcnt_q + WW'(1);
      end
      if (cmd_i.load_plain || cmd_i.load_empty || cmd_i.load_word) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

  always_comb begin
    sts_o            = '0;
    sts_o.eval_ok    = len_ok && (seq0 ? plen_ok : live_q);
    sts_o.do_insert  = !range_bad && !hit && !zero_len && !full;
    sts_o.write_last = (wc_q == 3'(flen_fill_q - 3'd1));
    sts_o.pkt_done   = (count_q == CW'(1)) && (st_q[0] == '0) &&
                       (ln_q[0] >= VW'(exp_q));
    sts_o.pkt_empty  = (exp_q == '0);
    sts_o.rd_done    = (rb_q == 4'(frim_pkg::WORD_BYTES));
    sts_o.words_more = ({wnext, 3'b000}) < (WW+4)'(exp_q);
    sts_o.out_free   = !out_valid_q || !out_stall_i;
  end

endmodule

`default_nettype wire

// ----- rtl/core/frim_chk.sv -----
// Port-level checker for the fragment reassembly unit, with its bind.
// Depends only on the top level's ports.
`default_nettype none

module frim_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic        ack_o,
  input wire logic        complete_o,
  input wire logic [63:0] packet_word_o,
  input wire logic [3:0]  word_bytes_o,
  input wire logic        last_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(packet_word_o) && $stable(last_o))
    else $error("stalled result changed");

  a_complete_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && complete_o |-> ack_o)
    else $error("completed packet without acknowledge");

  a_plain_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !complete_o |-> last_o && (word_bytes_o == 4'd0) && (packet_word_o == 64'd0))
    else $error("plain result carries data");

  a_word_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && complete_o && !last_o |-> (word_bytes_o == 4'd8))
    else $error("inner packet word not full");

endmodule

bind fragment_reassembly_interval_merge_unit frim_chk u_frim_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .ack_o         (ack_o),
  .complete_o    (complete_o),
  .packet_word_o (packet_word_o),
  .word_bytes_o  (word_bytes_o),
  .last_o        (last_o)
);

`default_nettype wire

// ----- sim/tb_top.sv -----
// Testbench for fragment_reassembly_interval_merge_unit: frames go in, and each
// result is checked against a behavioral predictor of the reassembly buffer.
// Depends on frim_pkg and the unit's RTL.
`timescale 1ns / 100ps

module tb_top;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SEQ_STEP    = frim_pkg::FRAME_BYTES - 1;

  typedef struct {
    bit        ack;
    bit        complete;
    bit [7:0]  command;
    bit [63:0] word;
    bit [3:0]  nbytes;
    bit [7:0]  total;
    bit        last;
  } reassembly_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [63:0] frame_bytes_i = '0;
  logic [7:0]  frame_length_i = '0;
  logic [7:0]  command_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        ack_o;
  logic        complete_o;
  logic [7:0]  packet_command_o;
  logic [63:0] packet_word_o;
  logic [3:0]  word_bytes_o;
  logic [7:0]  packet_total_o;
  logic        last_o;

  // Predictor state.
  bit [7:0] store_bytes[frim_pkg::STORE_BYTES];
  int       want_len;
  bit       live;
  int       iv_start[frim_pkg::MAX_INTERVALS + 1];
  int       iv_len[frim_pkg::MAX_INTERVALS + 1];
  int       iv_count;

  reassembly_result_t expected_q[$];
  int  mismatches;
  int  cycle_count;
  bit  idle_on;
  int  hold_len;
  int  frames_sent;

  always #5 clk_i = ~clk_i;

  fragment_reassembly_interval_merge_unit i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .frame_bytes_i, .frame_length_i,
    .command_i, .out_valid_o, .out_stall_i, .ack_o, .complete_o, .packet_command_o,
    .packet_word_o, .word_bytes_o, .packet_total_o, .last_o
  );

  task automatic drop_interval(input int pos);
    for (int i = pos; i + 1 < iv_count; i++) begin
      iv_start[i] = iv_start[i + 1];
      iv_len[i]   = iv_len[i + 1];
    end
    iv_count--;
  endtask

  task automatic predict_frame(input logic [63:0] fb, input logic [7:0] fl,
                               input logic [7:0] cm);
    reassembly_result_t r;
    int seq, lcode, t, plen, off, flen, src, pos, e, nwords, nb;
    bit [63:0] w;
    r = '{ack: 0, complete: 0, command: 0, word: 0, nbytes: 0, total: 0, last: 1};
    if (fl < frim_pkg::MIN_FLEN || fl > frim_pkg::FRAME_BYTES) begin
      expected_q.push_back(r);
      return;
    end
    seq   = int'(fb[7:frim_pkg::SEQ_SHIFT]);
    lcode = int'(fb[7:0] & frim_pkg::LCODE_MASK);
    if (lcode + 1 != fl) begin
      expected_q.push_back(r);
      return;
    end
    if (seq == 0) begin
      t    = int'(fb[15:8]);
      plen = (t / frim_pkg::FRAME_BYTES) * SEQ_STEP + (t % frim_pkg::FRAME_BYTES) - 2;
      if (plen < 0 || plen > frim_pkg::STORE_BYTES || plen > 255) begin
        expected_q.push_back(r);
        return;
      end
      foreach (store_bytes[i]) store_bytes[i] = '0;
      want_len = plen;
      live     = 1'b1;
      iv_count = 0;
      off      = 0;
      flen     = lcode - 1;
      src      = frim_pkg::SEQ0_SRC;
    end else begin
      if (!live) begin
        expected_q.push_back(r);
        return;
      end
      off  = seq * SEQ_STEP - 1;
      flen = lcode;
      src  = frim_pkg::SEQN_SRC;
    end
    if (off + flen > frim_pkg::STORE_BYTES) begin
      expected_q.push_back(r);
      return;
    end
    // A fill that starts inside a stored interval is a duplicate or a partial overlap.
    for (int i = 0; i < iv_count; i++) begin
      e = iv_start[i] + iv_len[i];
      if (off >= iv_start[i] && off < e) begin
        r.ack = (off + flen <= e);
        expected_q.push_back(r);
        return;
      end
    end
    if (flen == 0) begin
      r.ack = (iv_count == 1);
      expected_q.push_back(r);
      return;
    end
    if (iv_count >= frim_pkg::MAX_INTERVALS) begin
      expected_q.push_back(r);
      return;
    end
    pos = iv_count;
    for (int i = 0; i < iv_count; i++) begin
      if (iv_start[i] > off) begin
        pos = i;
        break;
      end
    end
    for (int i = iv_count; i > pos; i--) begin
      iv_start[i] = iv_start[i - 1];
      iv_len[i]   = iv_len[i - 1];
    end
    iv_start[pos] = off;
    iv_len[pos]   = flen;
    iv_count++;
    if (pos > 0 && iv_start[pos - 1] + iv_len[pos - 1] == off) begin
      iv_len[pos - 1] += flen;
      drop_interval(pos);
      pos--;
    end
    if (pos + 1 < iv_count && iv_start[pos] + iv_len[pos] == iv_start[pos + 1]) begin
      iv_len[pos] += iv_len[pos + 1];
      drop_interval(pos + 1);
    end
    for (int i = 0; i < flen; i++) begin
      if (off + i < frim_pkg::STORE_BYTES && src + i < 8)
        store_bytes[off + i] = fb[8 * (src + i) +: 8];
    end
    r.ack = (iv_count == 1);
    if (iv_count != 1 || iv_start[pos] != 0 || iv_len[pos] < want_len) begin
      expected_q.push_back(r);
      return;
    end
    live = 1'b0;
    r.complete = 1'b1;
    r.command  = cm;
    nwords = (want_len + 7) / 8;
    if (nwords == 0) begin
      expected_q.push_back(r);
      return;
    end
    for (int wi = 0; wi < nwords; wi++) begin
      nb = want_len - 8 * wi;
      if (nb > 8) nb = 8;
      w = '0;
      for (int b = 0; b < nb; b++) w[8 * b +: 8] = store_bytes[8 * wi + b];
      r.word   = w;
      r.nbytes = 4'(nb);
      r.total  = 8'(want_len);
      r.last   = (wi + 1 == nwords);
      expected_q.push_back(r);
    end
  endtask

  // Offers one request and holds it until accepted, then maybe idles.
  task automatic send_frame(input logic [63:0] fb, input logic [7:0] fl,
                            input logic [7:0] cm);
    in_valid_i     <= 1'b1;
    frame_bytes_i  <= fb;
    frame_length_i <= fl;
    command_i      <= cm;
    do @(posedge clk_i); while (in_stall_o);
    predict_frame(fb, fl, cm);
    frames_sent++;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
  endtask

  function automatic logic [63:0] make_frame(input int seq, input int lcode, input int total);
    logic [63:0] fb;
    fb = {$urandom, $urandom};
    fb[7:0] = {seq[4:0], lcode[2:0]};
    if (seq == 0) fb[15:8] = total[7:0];
    return fb;
  endfunction

  task automatic send_part(input int seq, input int flen, input int total);
    send_frame(make_frame(seq, flen - 1, total), 8'(flen), 8'($urandom_range(0, 255)));
  endtask

  task automatic wait_drain;
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic test_bad_lengths;
    send_frame(make_frame(0, 7, 20), 8'd0, 8'h00);
    send_frame(make_frame(0, 0, 20), 8'd1, 8'hff);
    send_frame(make_frame(0, 7, 20), 8'd9, 8'h5a);
    send_frame(64'hffff_ffff_ffff_ffff, 8'd255, 8'ha5);
    send_frame(make_frame(0, 3, 20), 8'd6, 8'h11);
    send_part(3, 8, 0);   // no first frame yet
    wait_drain();
  endtask

  task automatic test_first_frame;
    send_part(0, 8, 0);   // total too small
    send_part(0, 8, 1);
    send_part(0, 3, 2);   // empty packet completes at once
    send_part(0, 8, 10);
    send_part(1, 2, 10);  // completes a seven-byte packet
    send_part(1, 8, 10);  // buffer no longer live
    wait_drain();
  endtask

  task automatic test_duplicates;
    send_part(0, 8, 30);
    send_part(1, 8, 30);
    send_part(1, 5, 30);  // covered duplicate
    send_part(3, 3, 30);
    send_part(3, 8, 30);  // partial overlap
    send_part(0, 2, 30);  // empty first frame
    wait_drain();
  endtask

  task automatic test_full_table;
    send_part(0, 8, 255);
    for (int s = 2; s <= 16; s += 2) send_part(s, 8, 255);
    send_part(1, 8, 255);
    send_part(0, 8, 255); // a live buffer is reset by a new first frame
    wait_drain();
  endtask

  // One packet with random content, mostly in order, sometimes shuffled.
  task automatic send_packet(input int total);
    int seqs[$];
    int plen, last_seq, a, b, tmp;
    plen = (total / frim_pkg::FRAME_BYTES) * SEQ_STEP + (total % frim_pkg::FRAME_BYTES) - 2;
    last_seq = (plen <= 6) ? 0 : (plen - 6 + SEQ_STEP - 1) / SEQ_STEP;
    for (int s = 1; s <= last_seq; s++) seqs.push_back(s);
    if (seqs.size() > 1 && $urandom_range(0, 2) == 0) begin
      repeat (2) begin
        a = $urandom_range(0, seqs.size() - 1);
        b = $urandom_range(0, seqs.size() - 1);
        tmp = seqs[a];
        seqs[a] = seqs[b];
        seqs[b] = tmp;
      end
    end
    send_part(0, ($urandom_range(0, 5) == 0) ? $urandom_range(2, 8) : 8, total);
    foreach (seqs[i]) begin
      if ($urandom_range(0, 9) == 0)
        send_frame({$urandom, $urandom}, 8'($urandom_range(0, 10)),
                   8'($urandom_range(0, 255)));
      send_part(seqs[i], (i == seqs.size() - 1) ? $urandom_range(2, 8) : 8, total);
      if ($urandom_range(0, 12) == 0) send_part(seqs[i], $urandom_range(2, 8), total);
    end
  endtask

  task automatic test_random_packets(input int frame_goal);
    int start;
    start = frames_sent;
    while (frames_sent - start < frame_goal) begin
      if ($urandom_range(0, 9) == 0) send_packet($urandom_range(0, 255));
      else send_packet($urandom_range(2, 40));
    end
    wait_drain();
  endtask

  task automatic test_output_backpressure;
    hold_len = 300;
    repeat (2) send_packet($urandom_range(20, 60));
    wait_drain();
  endtask

  // Output stall: random bursts, and a long hold when a test asks for one.
  initial begin
    forever begin
      if (hold_len > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold_len) @(posedge clk_i);
        hold_len = 0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    reassembly_result_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: ack=%0b complete=%0b", ack_o, complete_o);
      end else begin
        exp_r = expected_q.pop_front();
        if (ack_o !== exp_r.ack || complete_o !== exp_r.complete
            || packet_command_o !== exp_r.command || packet_word_o !== exp_r.word
            || word_bytes_o !== exp_r.nbytes || packet_total_o !== exp_r.total
            || last_o !== exp_r.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch expected: ack=%0b cmp=%0b cmd=%h word=%h nb=%0d tot=%0d last=%0b",
                     exp_r.ack, exp_r.complete, exp_r.command, exp_r.word, exp_r.nbytes,
                     exp_r.total, exp_r.last);
            $display("         actual:   ack=%0b cmp=%0b cmd=%h word=%h nb=%0d tot=%0d last=%0b",
                     ack_o, complete_o, packet_command_o, packet_word_o, word_bytes_o,
                     packet_total_o, last_o);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    want_len = 0;
    live     = 1'b0;
    iv_count = 0;
    idle_on  = 1'b1;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_bad_lengths();
    test_first_frame();
    test_duplicates();
    test_full_table();
    test_random_packets(40);
    test_output_backpressure();
    idle_on = 1'b0;
    test_random_packets(12);
    repeat (50) @(posedge clk_i);
    if (expected_q.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- fragment_reassembly_interval_merge_unit.f -----
rtl/core/frim_pkg.sv
rtl/core/frim_ctrl.sv
rtl/core/frim_dp.sv
rtl/core/fragment_reassembly_interval_merge_unit.sv
rtl/core/frim_chk.sv
sim/tb_top.sv
